[hw/rtl/cmst_pkg.sv]
// ----------------------------------------------------------------------------
// CAN message slot table package
// Shared widths, operation codes, the slot entry layout and the state type.
// ----------------------------------------------------------------------------
package cmst_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int MAX_BYTES = 8;

  localparam int FUNC_W  = 3;
  localparam int SLOT_W  = 4;
  localparam int ID_W    = 29;
  localparam int LEN_W   = 4;
  localparam int BYTES_W = 8 * MAX_BYTES;
  localparam int COUNT_W = 16;
  localparam int TAG_W   = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD     = 3'd0,
    FUNC_READ    = 3'd1,
    FUNC_DEL     = 3'd2,
    FUNC_DEL_ID  = 3'd3,
    FUNC_SET_TAG = 3'd4,
    FUNC_CLEAR   = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [LEN_W-1:0]   len;
    logic [BYTES_W-1:0] bytes;
    logic [COUNT_W-1:0] count;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Byte lanes that an add replaces: the low len bytes, and only for a
  // length code from 1 to MAX_BYTES.
  function automatic logic [BYTES_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [BYTES_W-1:0] mask;
    mask = '0;
    for (int b = 0; b < MAX_BYTES; b++) begin
      if (len >= LEN_W'(1) && len <= LEN_W'(MAX_BYTES) && LEN_W'(b) < len) begin
        mask[b*8 +: 8] = 8'hFF;
      end
    end
    return mask;
  endfunction

endpackage

[hw/rtl/can_message_slot_table.sv]
// ----------------------------------------------------------------------------
// CAN message slot table
// A table of SLOTS frame slots with add, read, delete, delete by identifier,
// set tag and clear all operations, one result beat per input beat.
// ----------------------------------------------------------------------------
// Slot contents live in one RAM with registered read data; valid bits and
// written-once bits sit in flip-flops, so reset takes effect at once and a
// slot never written reads as zero. Read, delete slot and set tag fetch the
// slot, then update it and form the result in the final step; a slot index
// outside the table skips the fetch. Add and delete by identifier sweep
// every slot through the RAM read port, one slot per cycle. An add that
// stores its frame then fetches the chosen slot; an add that finds the table
// full and a delete by identifier go from the sweep to the final step; clear
// all and unknown codes go straight to it. A finished result waits in the
// output register; the next beat is accepted while it waits, and only the
// final step of that next beat holds until the output register is free.
module can_message_slot_table
  import cmst_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [FUNC_W-1:0]         func,
  input  logic [SLOT_W-1:0]         slot,
  input  logic [ID_W-1:0]           msg_id,
  input  logic [LEN_W-1:0]          msg_len,
  input  logic [BYTES_W-1:0]        msg_bytes,
  input  logic signed [TAG_W-1:0]   tag_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      ok,
  output logic                      slot_valid,
  output logic [ID_W-1:0]           out_id,
  output logic [LEN_W-1:0]          out_len,
  output logic [BYTES_W-1:0]        out_bytes,
  output logic [COUNT_W-1:0]        out_count,
  output logic signed [TAG_W-1:0]   out_tag
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  state_t state, state_next;

  logic             cover_mode;
  logic [SLOTS-1:0] slot_vld;
  logic [SLOTS-1:0] slot_wr;

  // Operation held for the duration of one beat.
  func_t              func_r;
  logic [ID_W-1:0]    id_r;
  logic [LEN_W-1:0]   len_r;
  logic [BYTES_W-1:0] bytes_r;
  logic [TAG_W-1:0]   tag_r;

  logic [CNT_W-1:0] iss_cnt;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_idx;
  logic             hit_found;
  logic [IDX_W-1:0] hit_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             tgt_ok;
  logic [IDX_W-1:0] tgt_idx;

  logic             ram_we;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t           new_e;

  logic   accept;
  logic   in_range;
  logic   iss_more;
  logic   scan_done;
  logic   res_load;
  entry_t cmp_e;
  entry_t tgt_e;
  logic   id_eq;
  logic   res_ok;
  logic   res_vld;
  logic   res_show;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign in_range  = 32'(slot) < 32'(SLOTS);
  assign iss_more  = iss_cnt < CNT_W'(SLOTS);
  assign scan_done = !iss_more && !cmp_vld;
  assign res_load  = !out_valid || !out_stall;

  // A slot that was never written reads as its reset value of zero.
  assign cmp_e = slot_wr[cmp_idx] ? entry_t'(ram_rdata) : '0;
  assign tgt_e = slot_wr[tgt_idx] ? entry_t'(ram_rdata) : '0;
  assign id_eq = (cmp_e.id == id_r);

  assign ram_re    = (state == ST_SCAN && iss_more) || state == ST_FETCH;
  assign ram_raddr = (state == ST_FETCH) ? tgt_idx : iss_cnt[IDX_W-1:0];
  assign ram_we    = state == ST_FINISH && res_load && tgt_ok &&
                     (func_r == FUNC_ADD || func_r == FUNC_SET_TAG);

  cmst_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tgt_idx),
    .wdata(new_e),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Modified entry and result for the final step of a beat.
  always_comb begin
    logic [BYTES_W-1:0] mask;
    mask     = byte_mask(len_r);
    new_e    = tgt_e;
    res_ok   = 1'b0;
    res_vld  = 1'b0;
    res_show = 1'b0;
    case (func_r)
      FUNC_ADD: begin
        new_e.id    = id_r;
        new_e.len   = len_r;
        new_e.bytes = (tgt_e.bytes & ~mask) | (bytes_r & mask);
        if (hit_found) begin
          new_e.count = (tgt_e.count == '1) ? tgt_e.count : tgt_e.count + COUNT_W'(1);
        end else begin
          new_e.count = COUNT_W'(1);
          new_e.tag   = '0;
        end
        res_ok   = tgt_ok;
        res_vld  = tgt_ok;
        res_show = tgt_ok;
      end
      FUNC_READ: begin
        res_ok   = 1'b1;
        res_vld  = tgt_ok && slot_vld[tgt_idx];
        res_show = tgt_ok;
      end
      FUNC_DEL: begin
        res_ok   = 1'b1;
        res_show = tgt_ok;
      end
      FUNC_SET_TAG: begin
        new_e.tag = tag_r;
        res_ok    = 1'b1;
        res_vld   = tgt_ok && slot_vld[tgt_idx];
        res_show  = tgt_ok;
      end
      FUNC_DEL_ID, FUNC_CLEAR: begin
        res_ok = 1'b1;
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (func_t'(func))
            FUNC_ADD, FUNC_DEL_ID: state_next = ST_SCAN;
            FUNC_READ, FUNC_DEL, FUNC_SET_TAG:
              state_next = in_range ? ST_FETCH : ST_FINISH;
            default: state_next = ST_FINISH;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          if (func_r == FUNC_ADD && (hit_found || free_found)) begin
            state_next = ST_FETCH;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_FETCH: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (res_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control state: configuration, valid bits, scan bookkeeping, output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      cover_mode <= 1'b0;
      slot_vld   <= '0;
      slot_wr    <= '0;
      iss_cnt    <= '0;
      cmp_vld    <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      tgt_ok     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        cover_mode <= cfg_wdata;
      end

      if (accept) begin
        iss_cnt    <= '0;
        cmp_vld    <= 1'b0;
        hit_found  <= 1'b0;
        free_found <= 1'b0;
        tgt_ok     <= in_range && (func_t'(func) == FUNC_READ ||
                                   func_t'(func) == FUNC_DEL ||
                                   func_t'(func) == FUNC_SET_TAG);
      end

      if (state == ST_SCAN) begin
        cmp_vld <= iss_more;
        if (iss_more) begin
          iss_cnt <= iss_cnt + CNT_W'(1);
        end
        if (cmp_vld) begin
          if (func_r == FUNC_ADD) begin
            if (cover_mode && slot_vld[cmp_idx] && id_eq && !hit_found) begin
              hit_found <= 1'b1;
            end
            if (!slot_vld[cmp_idx] && !free_found) begin
              free_found <= 1'b1;
            end
          end else if (id_eq) begin
            // Delete by identifier matches valid and invalid slots alike.
            slot_vld[cmp_idx] <= 1'b0;
          end
        end
        if (scan_done) begin
          tgt_ok <= func_r == FUNC_ADD && (hit_found || free_found);
        end
      end

      if (state == ST_FINISH && res_load) begin
        if (func_r == FUNC_CLEAR) begin
          slot_vld <= '0;
        end else if (tgt_ok) begin
          if (func_r == FUNC_ADD) begin
            slot_vld[tgt_idx] <= 1'b1;
          end else if (func_r == FUNC_DEL) begin
            slot_vld[tgt_idx] <= 1'b0;
          end
        end
        if (ram_we) begin
          slot_wr[tgt_idx] <= 1'b1;
        end
      end

      if (state == ST_FINISH && res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= func_t'(func);
      id_r    <= msg_id;
      len_r   <= msg_len;
      bytes_r <= msg_bytes;
      tag_r   <= tag_value;
      tgt_idx <= IDX_W'(slot);
    end

    if (state == ST_SCAN) begin
      cmp_idx <= iss_cnt[IDX_W-1:0];
      if (cmp_vld && func_r == FUNC_ADD) begin
        if (cover_mode && slot_vld[cmp_idx] && id_eq && !hit_found) begin
          hit_idx <= cmp_idx;
        end
        if (!slot_vld[cmp_idx] && !free_found) begin
          free_idx <= cmp_idx;
        end
      end
      if (scan_done) begin
        tgt_idx <= hit_found ? hit_idx : free_idx;
      end
    end

    if (state == ST_FINISH && res_load) begin
      ok         <= res_ok;
      slot_valid <= res_vld;
      out_id     <= res_show ? new_e.id : '0;
      out_len    <= res_show ? new_e.len : '0;
      out_bytes  <= res_show ? new_e.bytes : '0;
      out_count  <= res_show ? new_e.count : '0;
      out_tag    <= res_show ? new_e.tag : '0;
    end
  end

  // A result beat only appears after the final step of an operation.
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result beat raised outside the final step");

  // The sweep never runs past the last slot.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    iss_cnt <= CNT_W'(SLOTS))
    else $error("slot sweep counter out of range");

  // Every accepted beat starts work at once.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("accepted beat did not start");

  // An add that found no slot must not write the RAM.
  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> tgt_ok)
    else $error("RAM write without a target slot");

endmodule

[hw/rtl/cmst_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cmst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
